// File: rtl/b64e_pkg.sv
// Shared types and the sextet-to-character map of the base64 encoder.
// Used by b64e_split, b64e_outq and base64_unpadded_encoder.
package b64e_pkg;

  localparam int unsigned CharW   = 7;
  localparam int unsigned SextetW = 6;
  localparam int unsigned ByteW   = 8;

  // Position of the next byte within its three-byte group.
  typedef enum logic [2:0] {
    PH_0 = 3'b001,
    PH_1 = 3'b010,
    PH_2 = 3'b100
  } phase_t;

  // One or two characters that a single input byte completes. Only the
  // second character can ever close a message.
  typedef struct packed {
    logic             valid;
    logic             two;
    logic [CharW-1:0] c0;
    logic [CharW-1:0] c1;
    logic             last;
  } pair_t;

  // Status of the splitting stage.
  typedef struct packed {
    phase_t phase;
    logic   consume;
    logic   last;
  } split_stat_t;

  // Status of the result queue.
  typedef struct packed {
    logic [1:0] count;
  } q_stat_t;

  function automatic logic [CharW-1:0] sextet_to_char(input logic [SextetW-1:0] v);
    logic [CharW-1:0] v7;
    v7 = {1'b0, v};
    if (v < 6'd26) begin
      return 7'd65 + v7;
    end else if (v < 6'd52) begin
      return 7'd71 + v7;
    end else if (v < 6'd62) begin
      return v7 - 7'd4;
    end else if (v == 6'd62) begin
      return 7'd43;
    end
    return 7'd47;
  endfunction

endpackage

// File: rtl/b64e_split.sv
// Input register and group tracking: turns one byte into its base64 characters.
// Depends on b64e_pkg.
module b64e_split
  import b64e_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [ByteW-1:0]  in_byte,
  input  logic              in_last,
  input  logic              take,
  output pair_t             pair,
  output split_stat_t       stat
);

  logic             v_r, v_nxt;
  logic [ByteW-1:0] byte_r;
  logic             last_r;
  phase_t           phase_r, phase_nxt;
  logic [ByteW-1:0] held_r, held_nxt;
  logic [SextetW-1:0] s0, s1;
  logic             two;
  logic             consume;
  phase_t           phase_adv;

  assign consume  = v_r && take;
  assign in_ready = !v_r || take;

  always_comb begin
    case (phase_r)
      PH_1: begin
        s0        = {held_r[1:0], byte_r[7:4]};
        s1        = {byte_r[3:0], 2'b00};
        two       = last_r;
        phase_adv = PH_2;
      end
      PH_2: begin
        s0        = {held_r[3:0], byte_r[7:6]};
        s1        = byte_r[5:0];
        two       = 1'b1;
        phase_adv = PH_0;
      end
      default: begin
        // Start of a group; an unexpected code is handled the same way.
        s0        = byte_r[7:2];
        s1        = {byte_r[1:0], 4'b0000};
        two       = last_r;
        phase_adv = PH_1;
      end
    endcase
  end

  always_comb begin
    pair.valid = v_r;
    pair.two   = two;
    pair.c0    = sextet_to_char(s0);
    pair.c1    = sextet_to_char(s1);
    pair.last  = last_r;
  end

  always_comb begin
    v_nxt     = in_ready ? in_valid : v_r;
    phase_nxt = phase_r;
    held_nxt  = held_r;
    if (consume) begin
      phase_nxt = last_r ? PH_0 : phase_adv;
      held_nxt  = last_r ? '0 : byte_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r     <= 1'b0;
      phase_r <= PH_0;
      held_r  <= '0;
    end else begin
      v_r     <= v_nxt;
      phase_r <= phase_nxt;
      held_r  <= held_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_r <= in_byte;
      last_r <= in_last;
    end
  end

  assign stat.phase   = phase_r;
  assign stat.consume = consume;
  assign stat.last    = last_r;

endmodule

// File: rtl/b64e_outq.sv
// Two-entry result queue that sends one character per cycle from a register while the receiver is ready.
// Depends on b64e_pkg.
module b64e_outq
  import b64e_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  pair_t            pair,
  output logic             take,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [CharW-1:0] out_char,
  output logic             out_last,
  output q_stat_t          stat
);

  logic [1:0]       count_r, count_nxt;
  logic [CharW-1:0] chr_r [2];
  logic             lst_r [2];
  logic [CharW-1:0] chr_nxt [2];
  logic             lst_nxt [2];
  logic             pop;
  logic [1:0]       kept;
  logic             push;

  assign pop       = (count_r != 2'd0) && out_ready;
  assign kept      = count_r - {1'b0, pop};
  // Room for both characters only when the queue drains to empty.
  assign take      = pair.two ? (kept == 2'd0) : (kept != 2'd2);
  assign push      = pair.valid && take;
  assign out_valid = (count_r != 2'd0);
  assign out_char  = chr_r[0];
  assign out_last  = lst_r[0];

  always_comb begin
    chr_nxt[0] = pop ? chr_r[1] : chr_r[0];
    lst_nxt[0] = pop ? lst_r[1] : lst_r[0];
    chr_nxt[1] = chr_r[1];
    lst_nxt[1] = lst_r[1];
    count_nxt  = kept;
    if (push) begin
      if (kept == 2'd0) begin
        chr_nxt[0] = pair.c0;
        lst_nxt[0] = 1'b0;
        if (pair.two) begin
          chr_nxt[1] = pair.c1;
          lst_nxt[1] = pair.last;
          count_nxt  = 2'd2;
        end else begin
          count_nxt  = 2'd1;
        end
      end else begin
        chr_nxt[1] = pair.c0;
        lst_nxt[1] = 1'b0;
        count_nxt  = 2'd2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 2'd0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    chr_r[0] <= chr_nxt[0];
    chr_r[1] <= chr_nxt[1];
    lst_r[0] <= lst_nxt[0];
    lst_r[1] <= lst_nxt[1];
  end

  assign stat.count = count_r;

endmodule

// File: rtl/base64_unpadded_encoder.sv
// Top level of the unpadded base64 encoder.
// Depends on b64e_pkg, b64e_split and b64e_outq.

// Streaming base64 encoder, standard alphabet (A-Z, a-z, 0-9, '+', '/'),
// without '=' padding. Each input transfer carries one raw byte in
// in_tdata and marks the last byte of a message with in_tlast. Each output
// transfer carries one ASCII character in out_tdata[6:0]; out_tlast is set
// on the final character of a message. A group of three bytes gives four
// characters; a message that ends one or two bytes into a group is flushed
// with zero fill, giving two or three characters for that tail. After the
// last byte the encoder starts a new group, so messages may follow each
// other without any gap. Bytes pass through an input register, are split
// into characters by short logic, and wait in a two-entry output queue
// that sends one character per cycle while the receiver is ready. Most
// bytes yield one character; the third byte of a group and a message's
// last byte yield two. A new byte can enter the input register as the
// held one is taken, and the single output character per cycle bounds
// how fast bytes are taken.
module base64_unpadded_encoder
  import b64e_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] data_byte
  input  logic       in_tlast,   // final_byte
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [6:0] text_char, [7] zero
  output logic       out_tlast   // end_of_text
);

  pair_t            pair;
  split_stat_t      split_stat;
  q_stat_t          q_stat;
  logic             take;
  logic [CharW-1:0] out_char;

  // Input register and character split.
  b64e_split u_split (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_byte  (in_tdata),
    .in_last  (in_tlast),
    .take     (take),
    .pair     (pair),
    .stat     (split_stat)
  );

  // Result queue; it accepts a byte's characters only when they all fit.
  b64e_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .pair      (pair),
    .take      (take),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_char  (out_char),
    .out_last  (out_tlast),
    .stat      (q_stat)
  );

  assign out_tdata = {1'b0, out_char};

`ifndef SYNTHESIS
  // The queue never holds more than its two entries.
  a_q_bound : assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.count != 2'd3)
    else $error("result queue over capacity");

  // After a message's last byte is split, the next byte starts a new group.
  a_phase_restart : assert property (@(posedge clk) disable iff (!rst_n)
    (split_stat.consume && split_stat.last) |=> (split_stat.phase == PH_0))
    else $error("group phase not restarted after last byte");

  // Every character shown belongs to the base64 alphabet.
  a_alphabet : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((out_tdata >= 8'd65 && out_tdata <= 8'd90) ||
                    (out_tdata >= 8'd97 && out_tdata <= 8'd122) ||
                    (out_tdata >= 8'd48 && out_tdata <= 8'd57) ||
                    out_tdata == 8'd43 || out_tdata == 8'd47))
    else $error("character outside the base64 alphabet");
`endif

endmodule

// File: dv/tb_base64_unpadded_encoder.sv
// Self-checking testbench for the unpadded base64 encoder (stream in, stream out).
// Depends on b64e_pkg and base64_unpadded_encoder; a small class predicts and checks
// every output character.
module tb_base64_unpadded_encoder;
  import b64e_pkg::*;

  // The run is cut off here.
  localparam int CYCLE_LIMIT   = 400000;
  // How long the receiver refuses transfers in the back-pressure stretch.
  localparam int HOLD_CYCLES   = 300;
  // Cycles allowed after the last expected character.
  localparam int DRAIN_CYCLES  = 20;
  localparam int MAX_REPORTED  = 10;

  // One expected output transfer: the ASCII character and its end mark.
  typedef struct packed {
    logic [CharW-1:0] ch;
    logic             fin;
  } text_char_t;

  // Tracks the encoder's group position and the byte it still needs, and
  // keeps the characters that the bytes accepted so far must produce.
  class base64_char_book;
    phase_t     grp_phase;
    logic [7:0] prev_byte;
    text_char_t expected_chars[$];
    int         mismatches;

    function new();
      grp_phase  = PH_0;
      prev_byte  = 8'h00;
      mismatches = 0;
    endfunction

    // Standard alphabet: A-Z, a-z, 0-9, then plus and slash.
    function logic [CharW-1:0] sextet_ascii(logic [5:0] v);
      logic [7:0] c;
      if (v < 6'd26) begin
        c = "A" + {2'b00, v};
      end else if (v < 6'd52) begin
        c = "a" + {2'b00, v - 6'd26};
      end else if (v < 6'd62) begin
        c = "0" + {2'b00, v - 6'd52};
      end else if (v == 6'd62) begin
        c = "+";
      end else begin
        c = "/";
      end
      return c[CharW-1:0];
    endfunction

    function void push_char(logic [5:0] v, logic fin);
      text_char_t t;
      t.ch  = sextet_ascii(v);
      t.fin = fin;
      expected_chars.push_back(t);
    endfunction

    // Called for every accepted input byte. Sextets are cut from the most
    // significant bit first; a final byte flushes the partial group with
    // zero fill and the encoder starts a fresh group afterwards.
    function void note_byte(logic [7:0] b, logic fin);
      case (grp_phase)
        PH_1: begin
          push_char({prev_byte[1:0], b[7:4]}, 1'b0);
          if (fin) push_char({b[3:0], 2'b00}, 1'b1);
          grp_phase = PH_2;
        end
        PH_2: begin
          push_char({prev_byte[3:0], b[7:6]}, 1'b0);
          push_char(b[5:0], fin);
          grp_phase = PH_0;
        end
        default: begin
          push_char(b[7:2], 1'b0);
          if (fin) push_char({b[1:0], 4'b0000}, 1'b1);
          grp_phase = PH_1;
        end
      endcase
      prev_byte = b;
      if (fin) begin
        grp_phase = PH_0;
        prev_byte = 8'h00;
      end
    endfunction

    // Called for every accepted output transfer.
    function void check_char(logic [7:0] data, logic last);
      text_char_t t;
      if (expected_chars.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTED)
          $display("ERROR: unexpected character: data=%h last=%b", data, last);
        return;
      end
      t = expected_chars.pop_front();
      if (data !== {1'b0, t.ch} || last !== t.fin) begin
        mismatches++;
        if (mismatches <= MAX_REPORTED)
          $display("ERROR: character mismatch: expected data=%h last=%b, got data=%h last=%b",
                   {1'b0, t.ch}, t.fin, data, last);
      end
    endfunction

    function int pending();
      return expected_chars.size();
    endfunction
  endclass

  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       in_tvalid  = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata   = 8'h00;
  logic       in_tlast   = 1'b0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic       out_tlast;

  base64_unpadded_encoder DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  base64_char_book book = new();

  // Idle rates in percent. The sender rate is only read by the main
  // sequence; the receiver rate is updated at an edge and used at the next.
  int   tx_idle_pct = 20;
  int   rx_idle_pct = 74;
  int   bytes_sent  = 0;
  int   cycle_count = 0;
  logic hold_req    = 1'b0;

  // Entries are {final flag, byte}. Single-byte and two-byte messages hit
  // both flush paths with all-zero and all-one bytes, full groups of 0xFB
  // 0xEF 0xBE and 0xFF give the plus and slash characters, and the last
  // two messages run straight on into the next group.
  localparam logic [8:0] DIRECTED [22] = '{
    {1'b1, 8'h00},
    {1'b1, 8'hFF},
    {1'b0, 8'hFF}, {1'b1, 8'h00},
    {1'b0, 8'h00}, {1'b1, 8'hFF},
    {1'b0, 8'hFB}, {1'b0, 8'hEF}, {1'b1, 8'hBE},
    {1'b0, 8'hFF}, {1'b0, 8'hFF}, {1'b1, 8'hFF},
    {1'b0, 8'h00}, {1'b0, 8'h10}, {1'b0, 8'h83}, {1'b1, 8'h41},
    {1'b0, 8'h4D}, {1'b0, 8'h61}, {1'b0, 8'h6E}, {1'b0, 8'h20}, {1'b0, 8'h69},
    {1'b1, 8'h73}
  };

  // Offers one byte and returns at the edge where the transfer happens.
  // in_tvalid stays high, so a following call in the same step never
  // lowers and raises it.
  task automatic send_byte(input logic [7:0] b, input logic fin);
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= fin;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    book.note_byte(b, fin);
    bytes_sent++;
  endtask

  // Random gap after a transfer, drawn at the current sender idle rate.
  task automatic sender_gap();
    if ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
  endtask

  // Whole messages with random bytes. Most are short so that every tail
  // length and group boundary comes up often; a few are long.
  task automatic random_messages(input int n_bytes);
    int goal;
    int len;
    goal = bytes_sent + n_bytes;
    while (bytes_sent < goal) begin
      if ($urandom_range(9) == 0) len = $urandom_range(40, 9);
      else len = $urandom_range(8, 1);
      for (int i = 0; i < len; i++) begin
        send_byte(8'($urandom_range(255)), i == len - 1);
        sender_gap();
      end
    end
  endtask

  // The receiver accepts at random, except for one long hold-off that the
  // main sequence requests. During that hold-off the sender keeps offering
  // bytes, so the output queue fills and the encoder drops in_tready.
  initial begin
    int hold_left;
    bit hold_taken;
    hold_left  = 0;
    hold_taken = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = HOLD_CYCLES;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Every output transfer is checked against the oldest expected character.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) book.check_char(out_tdata, out_tlast);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("ERROR: timeout after %0d cycles", cycle_count);
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // First phase: the sender idles now and then, the receiver mostly.
    for (int i = 0; i < 22; i++) begin
      send_byte(DIRECTED[i][7:0], DIRECTED[i][8]);
      sender_gap();
    end
    hold_req <= 1'b1;
    random_messages(560);

    // Second phase: the rates swap, so the encoder mostly waits for input.
    tx_idle_pct = 74;
    rx_idle_pct <= 20;
    random_messages(580);

    // Third phase: no idling on either side, full throughput.
    tx_idle_pct = 0;
    rx_idle_pct <= 0;
    random_messages(580);

    in_tvalid <= 1'b0;
    in_tlast  <= 1'b0;
    while (book.pending() != 0) @(posedge clk);
    // Any character arriving now would be reported as unexpected.
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (book.mismatches == 0 && book.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: base64_unpadded_encoder.f
rtl/b64e_pkg.sv
rtl/b64e_split.sv
rtl/b64e_outq.sv
rtl/base64_unpadded_encoder.sv
dv/tb_base64_unpadded_encoder.sv
